FILE: src/bocl_pkg.sv
// Package for the box overlap cluster labeler: payload structs, widths and defaults.
// Used by every module of the block; depends on nothing.
package bocl_pkg;

    localparam int MaxBoxesDefault  = 32;
    localparam int CoordBitsDefault = 32;
    localparam int FieldBits        = 32;
    localparam int IndexBits        = 6;
    localparam logic [15:0] GapReset = 16'd512;

    typedef struct packed {
        logic signed [FieldBits-1:0] x_low;
        logic signed [FieldBits-1:0] y_low;
        logic signed [FieldBits-1:0] z_low;
        logic signed [FieldBits-1:0] x_high;
        logic signed [FieldBits-1:0] y_high;
        logic signed [FieldBits-1:0] z_high;
        logic                        box_empty;
        logic                        last_box;
    } box_word_t;

    typedef struct packed {
        logic [IndexBits-1:0] box_index;
        logic [IndexBits-1:0] cluster_number;
        logic                 starts_cluster;
        logic                 capacity_exceeded;
        logic                 last_result;
    } label_word_t;

endpackage

FILE: src/bocl_cell.sv
// One cell of the box chain: holds one stored box, its visited and queued marks.
// Depends on bocl_pkg. Each cycle it compares its box with the broadcast box.
module bocl_cell
    import bocl_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  logic signed [CW-1:0] load_lo [3],
    input  logic signed [CW-1:0] load_hi [3],
    input  logic                 load_empty,
    input  logic                 clear,
    input  logic                 probe_en,
    input  logic signed [CW-1:0] probe_lo [3],
    input  logic signed [CW-1:0] probe_hi [3],
    input  logic                 probe_empty,
    input  logic [16:0]          two_gap,
    input  logic                 mark_seed,
    input  logic                 take,
    output logic                 visited,
    output logic                 queued,
    output logic signed [CW-1:0] lo_out [3],
    output logic signed [CW-1:0] hi_out [3],
    output logic                 empty_out
);

    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];
    logic                 empty_reg;
    logic                 visited_reg, visited_next;
    logic                 queued_reg, queued_next;
    logic                 link;

    // Difference needs one extra bit; the tolerance is widened to match.
    always_comb
    begin
        logic signed [CW+1:0] d1, d2, g;
        link = !empty_reg && !probe_empty;
        g = $signed({{(CW-15){1'b0}}, two_gap});
        for (int k = 0; k < 3; k++)
        begin
            d1 = $signed({lo_reg[k][CW-1], lo_reg[k][CW-1], lo_reg[k]})
               - $signed({probe_hi[k][CW-1], probe_hi[k][CW-1], probe_hi[k]});
            d2 = $signed({probe_lo[k][CW-1], probe_lo[k][CW-1], probe_lo[k]})
               - $signed({hi_reg[k][CW-1], hi_reg[k][CW-1], hi_reg[k]});
            if (d1 > g || d2 > g)
                link = 1'b0;
        end
    end

    always_comb
    begin
        visited_next = visited_reg;
        queued_next  = queued_reg;
        if (clear)
        begin
            visited_next = 1'b0;
            queued_next  = 1'b0;
        end
        else
        begin
            if (mark_seed)
            begin
                visited_next = 1'b1;
                queued_next  = 1'b1;
            end
            if (probe_en && !visited_reg && link)
            begin
                visited_next = 1'b1;
                queued_next  = 1'b1;
            end
            if (take)
                queued_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
            queued_reg  <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
            queued_reg  <= queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            lo_reg    <= load_lo;
            hi_reg    <= load_hi;
            empty_reg <= load_empty;
        end
    end

    assign visited   = visited_reg;
    assign queued    = queued_reg;
    assign lo_out    = lo_reg;
    assign hi_out    = hi_reg;
    assign empty_out = empty_reg;

endmodule

FILE: src/box_overlap_cluster_labeler_core.sv
// Top level of the box overlap cluster labeler: load channel, label channel, gap register.
// Depends on bocl_pkg and bocl_cell.
//
// Usage. Boxes arrive on the box channel (box_valid, box_stall, box_word), one
// word a cycle while loading, each stored in the next cell of a row of MAX_BOXES
// cells. Boxes beyond the row are dropped and flagged on every label of the run.
// A word carrying last_box starts clustering: the block stalls the box channel
// until every label has been taken. Clustering is breadth-first: the lowest
// unvisited cell seeds a cluster; each visited box is broadcast to all cells for
// one cycle and every unvisited, linked cell marks itself queued. A queue order
// list, one slot per box, keeps visiting order. Each visited box gives one label
// word on the label channel (label_valid, label_stall). Each box passes through a
// select, a broadcast and an output step; the output step first adds each linked
// box it found to the order list, and a label stall holds it. A final select step
// reopens the box channel after the last label. A stalled label holds.
// The gap register is written through cfg_valid/cfg_ready/cfg_data; the user
// must write it only while idle, as the block does not enforce it; ready is always high.
// Reset empties the row, clears marks and sets the gap to 0.5 mm.
module box_overlap_cluster_labeler_core
    import bocl_pkg::*;
#(
    parameter int MAX_BOXES  = MaxBoxesDefault,
    parameter int COORD_BITS = CoordBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        box_valid,
    output logic        box_stall,
    input  box_word_t   box_word,
    output logic        label_valid,
    input  logic        label_stall,
    output label_word_t label_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int NB = $clog2(MAX_BOXES);
    localparam int CB = $clog2(MAX_BOXES + 1);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SEEK  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CB-1:0]    count_reg, count_next;
    logic             over_reg, over_next;
    logic [15:0]      gap_reg;
    logic [NB-1:0]    cur_reg, cur_next;
    logic             seedflag_reg, seedflag_next;
    logic [IndexBits-1:0] cluster_reg, cluster_next;
    logic [CB-1:0]    emitted_reg, emitted_next;
    logic             out_valid_reg, out_valid_next;
    label_word_t      out_reg, out_next;
    logic [NB-1:0]    order_reg [MAX_BOXES];
    logic [CB-1:0]    head_reg, head_next, tail_reg, tail_next;

    logic signed [CW-1:0] in_lo [3];
    logic signed [CW-1:0] in_hi [3];
    logic signed [CW-1:0] c_lo [MAX_BOXES][3];
    logic signed [CW-1:0] c_hi [MAX_BOXES][3];
    logic [MAX_BOXES-1:0] c_empty, c_visited, c_queued, c_load, c_seed, c_take;
    logic signed [CW-1:0] p_lo [3];
    logic signed [CW-1:0] p_hi [3];
    logic                 p_empty, probe_en, clear_all, accept, pend_seen;
    logic [NB-1:0]        low_unvisited, low_queued;
    logic                 any_unvisited, any_queued;

    assign in_lo[0] = box_word.x_low[CW-1:0];
    assign in_lo[1] = box_word.y_low[CW-1:0];
    assign in_lo[2] = box_word.z_low[CW-1:0];
    assign in_hi[0] = box_word.x_high[CW-1:0];
    assign in_hi[1] = box_word.y_high[CW-1:0];
    assign in_hi[2] = box_word.z_high[CW-1:0];

    assign box_stall = (state_reg != S_LOAD);
    assign accept    = box_valid && !box_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= GapReset;
        else if (cfg_valid)
            gap_reg <= cfg_data;
    end

    // Lowest unvisited cell within the fill, for the next seed, and lowest queued cell, for the order list.
    always_comb
    begin
        low_unvisited = '0;
        any_unvisited = 1'b0;
        for (int i = MAX_BOXES - 1; i >= 0; i--)
        begin
            if (CB'(i) < count_reg && !c_visited[i])
            begin
                low_unvisited = NB'(i);
                any_unvisited = 1'b1;
            end
        end
        low_queued = '0;
        any_queued = 1'b0;
        pend_seen  = 1'b0;
        for (int i = MAX_BOXES - 1; i >= 0; i--)
        begin
            if (c_queued[i])
            begin
                low_queued = NB'(i);
                any_queued = 1'b1;
            end
        end
        pend_seen = any_queued;
    end

    assign p_lo     = c_lo[cur_reg];
    assign p_hi     = c_hi[cur_reg];
    assign p_empty  = c_empty[cur_reg];
    assign probe_en = (state_reg == S_PROBE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        over_next      = over_reg;
        cur_next       = cur_reg;
        seedflag_next  = seedflag_reg;
        cluster_next   = cluster_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        c_load         = '0;
        c_seed         = '0;
        c_take         = '0;
        clear_all      = 1'b0;
        if (out_valid_reg && !label_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CB'(MAX_BOXES))
                    begin
                        c_load[count_reg[NB-1:0]] = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        over_next = 1'b1;
                    if (box_word.last_box)
                    begin
                        state_next   = S_SEEK;
                        cluster_next = '0;
                        emitted_next = '0;
                        head_next    = '0;
                        tail_next    = '0;
                    end
                end
            end
            S_SEEK:
            begin
                if (head_reg != tail_reg)
                begin
                    cur_next      = order_reg[head_reg[NB-1:0]];
                    head_next     = head_reg + 1'b1;
                    seedflag_next = 1'b0;
                    state_next    = S_PROBE;
                end
                else if (any_unvisited)
                begin
                    c_seed[low_unvisited] = 1'b1;
                    c_take[low_unvisited] = 1'b1;
                    cur_next      = low_unvisited;
                    seedflag_next = 1'b1;
                    if (emitted_reg != '0)
                        cluster_next = cluster_reg + 1'b1;
                    state_next    = S_PROBE;
                end
                else if (!out_valid_reg || !label_stall)
                begin
                    clear_all  = 1'b1;
                    count_next = '0;
                    over_next  = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_PROBE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Newly queued cells enter the order list one per cycle, lowest first.
                if (pend_seen)
                begin
                    c_take[low_queued] = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                else if (!out_valid_reg || !label_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_next.box_index       = IndexBits'(cur_reg);
                    out_next.cluster_number  = cluster_reg;
                    out_next.starts_cluster  = seedflag_reg;
                    out_next.capacity_exceeded = over_reg;
                    out_next.last_result     = (emitted_reg + 1'b1 == count_reg);
                    emitted_next             = emitted_reg + 1'b1;
                    state_next               = S_SEEK;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && pend_seen)
            order_reg[tail_reg[NB-1:0]] <= low_queued;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            cur_reg       <= '0;
            seedflag_reg  <= 1'b0;
            cluster_reg   <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            over_reg      <= over_next;
            cur_reg       <= cur_next;
            seedflag_reg  <= seedflag_next;
            cluster_reg   <= cluster_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    generate
        for (genvar g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            bocl_cell #(.CW(CW)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load_en     (c_load[g]),
                .load_lo     (in_lo),
                .load_hi     (in_hi),
                .load_empty  (box_word.box_empty),
                .clear       (clear_all),
                .probe_en    (probe_en && (CB'(g) < count_reg)),
                .probe_lo    (p_lo),
                .probe_hi    (p_hi),
                .probe_empty (p_empty),
                .two_gap     ({gap_reg, 1'b0}),
                .mark_seed   (c_seed[g]),
                .take        (c_take[g]),
                .visited     (c_visited[g]),
                .queued      (c_queued[g]),
                .lo_out      (c_lo[g]),
                .hi_out      (c_hi[g]),
                .empty_out   (c_empty[g])
            );
        end
    endgenerate

    assign label_valid = out_valid_reg;
    assign label_word  = out_reg;

    a_no_box_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> box_stall)
        else $error("box channel open during clustering");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(MAX_BOXES))
        else $error("box count beyond capacity");
    a_label_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (label_valid && label_stall) |=> $stable(label_word))
        else $error("stalled label changed");

endmodule
